// ----- design/fdl_pkg.sv -----
// Shared types and constants of the fractional delay line.
`timescale 1ns / 1ps

package fdl_pkg;

  localparam int DEPTH       = 65536;
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 16;
  localparam int ADDR_BITS   = $clog2(DEPTH);
  localparam int LEN_BITS    = 17;
  localparam int DELAY_BITS  = 32;
  localparam int ACC_BITS    = 32;
  localparam int CFG_IDX_BITS = 8;

  localparam logic [CFG_IDX_BITS-1:0] CFG_BUFFER_LENGTH = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_INTERP_MODE   = CFG_IDX_BITS'(1);

  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(DEPTH);

  typedef enum logic [1:0] {
    MODE_LINEAR,
    MODE_LAGRANGE,
    MODE_CUBIC,
    MODE_HERMITE
  } interp_mode_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_MOD,
    ST_BASE,
    ST_TAP,
    ST_WAIT,
    ST_COEF,
    ST_MAC,
    ST_FIN
  } fdl_state_t;

  // One request to the shared multiply-accumulate unit.
  typedef struct packed {
    logic                       load;
    logic                       step;
    logic signed [ACC_BITS-1:0] operand;
  } mac_req_t;

endpackage

// ----- design/fdl_mac.sv -----
// Shared multiply, round and add unit that holds the Horner accumulator.
`timescale 1ns / 1ps

module fdl_mac (
  input  logic                               clk,
  input  fdl_pkg::mac_req_t                  req,
  input  logic [fdl_pkg::FRAC_BITS-1:0]      frac,
  output logic signed [fdl_pkg::ACC_BITS-1:0] acc
);
  import fdl_pkg::*;

  localparam int PROD_BITS = ACC_BITS + FRAC_BITS + 1;

  localparam logic signed [PROD_BITS-1:0] HALF =
    $signed(PROD_BITS'(1) << (FRAC_BITS - 1));

  logic signed [PROD_BITS-1:0] prod;
  logic signed [PROD_BITS-1:0] rounded;
  logic signed [ACC_BITS-1:0]  scaled;

  assign prod    = acc * $signed({1'b0, frac});
  // Round to nearest, ties upward: add half, then floor shift.
  assign rounded = (prod + HALF) >>> FRAC_BITS;
  assign scaled  = $signed(rounded[ACC_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (req.load) begin
      acc <= req.operand;
    end else if (req.step) begin
      acc <= scaled + req.operand;
    end
  end

endmodule

// ----- design/fractional_delay_line_unit.sv -----
// Top level of the fractional delay line: sample store, sequencer and output stage.
//
// Input requests arrive on the s_ stream. s_tuser is the command: 0 stores the
// sample in s_tdata[23:0] at the next write position, 1 reads an interpolated
// sample at the Q16.16 delay in s_tdata[55:24]. Each read returns one result
// on the m_ stream (sample in m_tdata, clamp flag in m_tuser); writes return
// nothing. The user is to set interpolation mode and buffer length on the cfg
// channel while the block is idle, which it does not enforce; cfg_ready is always high.
//
// A write goes straight into the store. A read fetches two taps in linear mode
// and four in the others, one per cycle through the single read port of the
// store, and the Horner chain runs one step per cycle on the shared
// multiply-accumulate unit. When the write position lies at or beyond a
// shortened buffer length, a read first runs a restoring reduction.
//
// After reset the store is cleared at one slot per cycle with s_tready low. A
// finished result waits in the output register while the receiver stalls; new
// requests are still taken, and a following read holds in its last step until
// the output register frees up.
`timescale 1ns / 1ps

module fractional_delay_line_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [55:0]                         s_tdata,   // sample_in[23:0], delay_amount[55:24]
  input  logic                                s_tuser,   // cmd[0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [fdl_pkg::SAMPLE_BITS-1:0]     m_tdata,   // sample_out[23:0]
  output logic                                m_tuser,   // delay_clamped[0]
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fdl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [fdl_pkg::LEN_BITS-1:0]        cfg_data
);
  import fdl_pkg::*;

  localparam int SUM_BITS  = LEN_BITS + FRAC_BITS;
  localparam int MODK_BITS = $clog2(ADDR_BITS);
  localparam int DVS_BITS  = LEN_BITS + ADDR_BITS;
  localparam int TAP_BITS  = ADDR_BITS + 3;

  localparam logic signed [ACC_BITS-1:0] SAT_MAX =
    $signed(ACC_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1));
  localparam logic signed [ACC_BITS-1:0] SAT_MIN = -SAT_MAX - ACC_BITS'(1);

  function automatic logic signed [ACC_BITS-1:0] sx(input logic [SAMPLE_BITS-1:0] v);
    sx = $signed({{(ACC_BITS - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v});
  endfunction

  fdl_state_t   state, state_next;
  interp_mode_t mode;

  logic [LEN_BITS-1:0]  buf_len;
  logic [LEN_BITS-1:0]  len_eff;
  logic [ADDR_BITS-1:0] wp;
  logic [ADDR_BITS-1:0] wp_next;
  logic [ADDR_BITS-1:0] clr_cnt;

  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [ADDR_BITS-1:0]   rd_addr;
  logic                   mem_we;
  logic [ADDR_BITS-1:0]   mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;

  logic s_acc, cfg_wr, is_read;

  // Delay clamp
  logic [1:0]            lo_int;
  logic [1:0]            hi_sub;
  logic [LEN_BITS-1:0]   hi_int;
  logic [SUM_BITS-1:0]   lo_fx, hi_fx, dl_ext, dl_c;
  logic                  clamp_hit;

  logic [ADDR_BITS-1:0] dint;
  logic [FRAC_BITS-1:0] frac;
  logic                 clamped;

  // Write position reduction
  logic [ADDR_BITS-1:0] wpm;
  logic [MODK_BITS-1:0] mod_k;
  logic [DVS_BITS-1:0]  dvs, rem_ext;

  logic signed [ADDR_BITS+1:0] base_diff;
  logic [ADDR_BITS-1:0]        base;

  // Tap fetch
  logic [1:0]                 tap_k, tap_slot, tap_last;
  logic                       tap_pend;
  logic signed [2:0]          off0, off;
  logic signed [TAP_BITS-1:0] tap_pos;
  logic [SAMPLE_BITS-1:0]     taps [4];

  // Horner coefficients
  logic signed [ACC_BITS-1:0] t0, t1, t2, t3;
  logic signed [ACC_BITS-1:0] c_init, c_add0, c_add1, c_add2;
  logic signed [ACC_BITS-1:0] h_s0, h_s1, h_v, h_w, h_a, h_b, l_a;
  logic [1:0]                 c_last;
  logic signed [ACC_BITS-1:0] addend [3];
  logic [1:0]                 step_k, last_step;

  mac_req_t                   mac_req;
  logic signed [ACC_BITS-1:0] acc;
  logic signed [ACC_BITS-1:0] res_full;
  logic [SAMPLE_BITS-1:0]     res_sat;
  logic                       fin_load;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid & s_tready;
  assign is_read   = s_tuser;

  always_comb begin
    len_eff = buf_len;
    if (buf_len < LEN_BITS'(4)) begin
      len_eff = LEN_BITS'(4);
    end else if (buf_len > LEN_BITS'(DEPTH)) begin
      len_eff = LEN_BITS'(DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_len <= LEN_RESET;
      mode    <= MODE_LAGRANGE;
    end else if (cfg_wr) begin
      if (cfg_index == CFG_BUFFER_LENGTH) begin
        buf_len <= cfg_data;
      end else if (cfg_index == CFG_INTERP_MODE) begin
        mode <= interp_mode_t'(cfg_data[1:0]);
      end
    end
  end

  // Wrap the write position at the effective length.
  always_comb begin
    if ({1'b0, wp} + LEN_BITS'(1) >= len_eff) begin
      wp_next = '0;
    end else begin
      wp_next = wp + ADDR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= ADDR_BITS'(LEN_RESET - LEN_BITS'(1));
    end else if (s_acc && !is_read) begin
      wp <= wp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == ST_CLR) begin
      clr_cnt <= clr_cnt + ADDR_BITS'(1);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wp_next;
    mem_wdata = s_tdata[SAMPLE_BITS-1:0];
    if (state == ST_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (s_acc && !is_read) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  // Valid delay range of the mode, in whole samples.
  always_comb begin
    unique case (mode)
      MODE_LINEAR: begin
        lo_int = 2'd0;
        hi_sub = 2'd1;
      end
      MODE_HERMITE: begin
        lo_int = 2'd1;
        hi_sub = 2'd2;
      end
      default: begin
        lo_int = 2'd2;
        hi_sub = 2'd3;
      end
    endcase
    hi_int = len_eff - LEN_BITS'(hi_sub);
    if (hi_int < LEN_BITS'(lo_int)) begin
      hi_int = LEN_BITS'(lo_int);
    end
    lo_fx  = SUM_BITS'(lo_int) << FRAC_BITS;
    hi_fx  = SUM_BITS'(hi_int) << FRAC_BITS;
    dl_ext = SUM_BITS'(s_tdata[SAMPLE_BITS +: DELAY_BITS]);
    dl_c      = dl_ext;
    clamp_hit = 1'b0;
    if (dl_ext < lo_fx) begin
      dl_c      = lo_fx;
      clamp_hit = 1'b1;
    end else if (dl_ext > hi_fx) begin
      dl_c      = hi_fx;
      clamp_hit = 1'b1;
    end
  end

  assign dvs     = DVS_BITS'(len_eff) << mod_k;
  assign rem_ext = DVS_BITS'(wpm);

  // Tap position relative to the reduced write position.
  always_comb begin
    base_diff = $signed({2'b00, wpm}) - $signed({2'b00, dint});
    if (base_diff < 0) begin
      base_diff = base_diff + $signed({1'b0, len_eff});
    end
  end

  always_comb begin
    off0     = (mode == MODE_HERMITE) ? -3'sd2 : -3'sd1;
    off      = off0 + $signed({1'b0, tap_k});
    tap_last = (mode == MODE_LINEAR) ? 2'd1 : 2'd3;
    tap_pos  = $signed({3'b000, base}) + TAP_BITS'(off);
    if (tap_pos < 0) begin
      tap_pos = tap_pos + $signed({2'b00, len_eff});
    end else if (tap_pos >= $signed({2'b00, len_eff})) begin
      tap_pos = tap_pos - $signed({2'b00, len_eff});
    end
    rd_addr = tap_pos[ADDR_BITS-1:0];
  end

  always_comb begin
    t0 = sx(taps[0]);
    t1 = sx(taps[1]);
    t2 = sx(taps[2]);
    t3 = sx(taps[3]);
    // Hermite taps: E, C, B, A from oldest to newest.
    h_s0 = t1 - t3;
    h_s1 = t0 - t2;
    h_v  = (t2 - t1) <<< 1;
    h_w  = h_s0 + h_v;
    h_a  = h_w + h_v + h_s1;
    h_b  = h_w + h_a;
    l_a  = t1 - t0 - t2 + t3;
    unique case (mode)
      MODE_LINEAR: begin
        c_init = t0 - t1;
        c_add0 = t1;
        c_add1 = '0;
        c_add2 = '0;
        c_last = 2'd0;
      end
      MODE_LAGRANGE: begin
        c_init = l_a;
        c_add0 = t2 - t0 - l_a;
        c_add1 = t1 - t0;
        c_add2 = t0;
        c_last = 2'd2;
      end
      MODE_CUBIC: begin
        c_init = l_a;
        c_add0 = t0 - t1 - l_a;
        c_add1 = t2 - t0;
        c_add2 = t1;
        c_last = 2'd2;
      end
      MODE_HERMITE: begin
        c_init = h_a;
        c_add0 = -h_b;
        c_add1 = h_s0;
        c_add2 = t2 <<< 1;
        c_last = 2'd2;
      end
    endcase
  end

  // All taps are in place during ST_COEF, so seed the accumulator directly.
  always_comb begin
    mac_req.load    = (state == ST_COEF);
    mac_req.step    = (state == ST_MAC);
    mac_req.operand = (state == ST_COEF) ? c_init : addend[step_k];
  end

  fdl_mac u_mac (
    .clk  (clk),
    .req  (mac_req),
    .frac (frac),
    .acc  (acc)
  );

  always_comb begin
    if (mode == MODE_HERMITE) begin
      res_full = (acc + ACC_BITS'(1)) >>> 1;
    end else begin
      res_full = acc;
    end
    if (res_full > SAT_MAX) begin
      res_sat = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (res_full < SAT_MIN) begin
      res_sat = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      res_sat = res_full[SAMPLE_BITS-1:0];
    end
  end

  assign fin_load = (state == ST_FIN) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR: begin
        if (clr_cnt == ADDR_BITS'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_acc && is_read) begin
          state_next = ({1'b0, wp} >= len_eff) ? ST_MOD : ST_BASE;
        end
      end
      ST_MOD: begin
        if (mod_k == '0) begin
          state_next = ST_BASE;
        end
      end
      ST_BASE: state_next = ST_TAP;
      ST_TAP: begin
        if (tap_k == tap_last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: state_next = ST_COEF;
      ST_COEF: state_next = ST_MAC;
      ST_MAC: begin
        if (step_k == last_step) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        dint    <= dl_c[FRAC_BITS +: ADDR_BITS];
        frac    <= dl_c[FRAC_BITS-1:0];
        clamped <= clamp_hit;
        wpm     <= wp;
        mod_k   <= MODK_BITS'(ADDR_BITS - 1);
      end
      ST_MOD: begin
        if (rem_ext >= dvs) begin
          wpm <= ADDR_BITS'(rem_ext - dvs);
        end
        mod_k <= mod_k - MODK_BITS'(1);
      end
      ST_BASE: begin
        base  <= base_diff[ADDR_BITS-1:0];
        tap_k <= '0;
      end
      ST_TAP: begin
        tap_k <= tap_k + 2'd1;
      end
      ST_COEF: begin
        addend[0] <= c_add0;
        addend[1] <= c_add1;
        addend[2] <= c_add2;
        last_step <= c_last;
        step_k    <= '0;
      end
      ST_MAC: begin
        step_k <= step_k + 2'd1;
      end
      default: begin
      end
    endcase
  end

  // Capture each tap in the cycle after its read is issued, when its data arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_pend <= 1'b0;
    end else begin
      tap_pend <= (state == ST_TAP);
    end
  end

  always_ff @(posedge clk) begin
    tap_slot <= tap_k;
    if (tap_pend) begin
      taps[tap_slot] <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      m_tdata <= res_sat;
      m_tuser <= clamped;
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLR |-> !s_tready)
    else $error("request taken during store clearing");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_FIN)
    else $error("result raised outside the final step");

  a_wp_in_range: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser && !(cfg_valid && cfg_ready))
      |=> ({1'b0, wp} < len_eff))
    else $error("write position beyond buffer length after a write");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_MAC |-> step_k <= last_step)
    else $error("Horner step count overran");

  a_tap_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_TAP |-> tap_k <= tap_last)
    else $error("tap fetch overran");

endmodule

// ----- verif/fdl_tb_pkg.sv -----
// Command codes shared by the delay line testbench files.
`timescale 1ns / 1ps

package fdl_tb_pkg;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } fdl_cmd_t;

endpackage

// ----- verif/fdl_checker.sv -----
// Delay line checker: tracks the store, predicts each read and compares the results.
`timescale 1ns / 1ps

module fdl_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [55:0]                      s_tdata,   // sample_in[23:0], delay_amount[55:24]
  input  logic                             s_tuser,   // cmd[0]
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [fdl_pkg::SAMPLE_BITS-1:0]  m_tdata,   // sample_out[23:0]
  input  logic                             m_tuser,   // delay_clamped[0]
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [fdl_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [fdl_pkg::LEN_BITS-1:0]     cfg_data,
  output int                               errors,
  output int                               outstanding
);
  import fdl_pkg::*;
  import fdl_tb_pkg::*;

  localparam int     MIN_LEN = 4;
  localparam longint SAT_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_MIN = -SAT_MAX - 1;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          clamp;
  } read_result_t;

  logic signed [SAMPLE_BITS-1:0] ring [DEPTH];
  int                            wr_pos;
  logic [LEN_BITS-1:0]           len_reg;
  interp_mode_t                  mode_reg;
  read_result_t                  due_reads [$];
  read_result_t                  oldest;
  int                            mismatches;

  function automatic int eff_len(logic [LEN_BITS-1:0] raw);
    if (raw < MIN_LEN) return MIN_LEN;
    if (raw > DEPTH) return DEPTH;
    return int'(raw);
  endfunction

  // Round to nearest, ties toward plus infinity.
  function automatic longint rnd(longint x, int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint mulf(longint x, longint f);
    return rnd(x * f, FRAC_BITS);
  endfunction

  function automatic longint tap(int n, int d, int off);
    return longint'(ring[(wr_pos + 2 * n + off - d) % n]);
  endfunction

  function automatic read_result_t interpolate(logic [DELAY_BITS-1:0] raw);
    int           n;
    int           d;
    longint       lo, hi, dl, f, r, acc;
    longint       p0, p1, p2, p3, a, b, c, s0, s1, v, w;
    read_result_t res;
    n = eff_len(len_reg);
    case (mode_reg)
      MODE_LINEAR: begin
        lo = 0;
        hi = n - 1;
      end
      MODE_HERMITE: begin
        lo = 1;
        hi = n - 2;
      end
      default: begin
        lo = 2;
        hi = n - 3;
      end
    endcase
    if (hi < lo) hi = lo;
    lo = lo << FRAC_BITS;
    hi = hi << FRAC_BITS;
    dl = longint'(raw);
    res.clamp = 1'b0;
    if (dl < lo) begin
      dl = lo;
      res.clamp = 1'b1;
    end
    if (dl > hi) begin
      dl = hi;
      res.clamp = 1'b1;
    end
    d = int'(dl >>> FRAC_BITS);
    f = longint'(dl[FRAC_BITS-1:0]);
    case (mode_reg)
      MODE_LINEAR: begin
        p1 = tap(n, d, 0);
        p0 = tap(n, d, -1);
        r  = p1 + mulf(p0 - p1, f);
      end
      MODE_HERMITE: begin
        // p2 newest, p3 oldest; evaluate at twice scale, halve at the end
        p2  = tap(n, d, 1);
        p1  = tap(n, d, 0);
        p0  = tap(n, d, -1);
        p3  = tap(n, d, -2);
        s0  = p0 - p2;
        s1  = p3 - p1;
        v   = 2 * (p1 - p0);
        w   = s0 + v;
        a   = w + v + s1;
        b   = w + a;
        acc = mulf(a, f) - b;
        acc = mulf(acc, f) + s0;
        acc = mulf(acc, f) + 2 * p1;
        r   = rnd(acc, 1);
      end
      default: begin
        p0 = tap(n, d, -1);
        p1 = tap(n, d, 0);
        p2 = tap(n, d, 1);
        p3 = tap(n, d, 2);
        if (mode_reg == MODE_LAGRANGE) begin
          a   = p1 - p0 - p2 + p3;
          b   = p2 - p0 - a;
          c   = p1 - p0;
          acc = mulf(a, f) + b;
          acc = mulf(acc, f) + c;
          r   = p0 + mulf(acc, f);
        end else begin
          a   = p3 - p2 - p0 + p1;
          b   = p0 - p1 - a;
          c   = p2 - p0;
          acc = mulf(a, f) + b;
          acc = mulf(acc, f) + c;
          r   = mulf(acc, f) + p1;
        end
      end
    endcase
    if (r > SAT_MAX) r = SAT_MAX;
    if (r < SAT_MIN) r = SAT_MIN;
    res.smp = r[SAMPLE_BITS-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (ring[i]) ring[i] = '0;
      len_reg  = LEN_RESET;
      mode_reg = MODE_LAGRANGE;
      wr_pos   = eff_len(LEN_RESET) - 1;
      due_reads.delete();
      mismatches = 0;
    end else begin
      // Compare first: a result never belongs to a request taken at the same edge.
      if (m_tvalid && m_tready) begin
        if (due_reads.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: unexpected result sample_out=%h delay_clamped=%b",
                     m_tdata, m_tuser);
        end else begin
          oldest = due_reads.pop_front();
          if (oldest.smp !== m_tdata || oldest.clamp !== m_tuser) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: sample_out exp %h got %h, delay_clamped exp %b got %b",
                       oldest.smp, m_tdata, oldest.clamp, m_tuser);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BUFFER_LENGTH)
          len_reg = cfg_data;
        else if (cfg_index == CFG_INTERP_MODE)
          mode_reg = interp_mode_t'(cfg_data[1:0]);
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_WRITE) begin
          wr_pos++;
          if (wr_pos >= eff_len(len_reg)) wr_pos = 0;
          ring[wr_pos] = s_tdata[SAMPLE_BITS-1:0];
        end else begin
          due_reads.push_back(interpolate(s_tdata[55:24]));
        end
      end
    end
    errors      <= mismatches;
    outstanding <= due_reads.size();
  end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the fractional delay line: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb;
  import fdl_pkg::*;
  import fdl_tb_pkg::*;

  localparam int IDLE_PCT    = 28;
  localparam int HOLD_CYCLES = 500;
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 900000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int MIN_LEN     = 4;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [55:0]             s_tdata   = '0;
  logic                    s_tuser   = CMD_WRITE;
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [SAMPLE_BITS-1:0]  m_tdata;
  logic                    m_tuser;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [LEN_BITS-1:0]     cfg_data  = '0;

  int   errors;
  int   outstanding;
  int   cycles    = 0;
  int   cur_len   = DEPTH;
  bit   idle_on   = 1'b1;
  bit   hold_arm  = 1'b0;
  logic sink_hold = 1'b0;

  logic [SAMPLE_BITS-1:0] extreme_samples [8] = '{
    24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
    24'h000000, 24'hFFFFFF, 24'h000001, 24'h7FFFFF
  };
  logic [DELAY_BITS-1:0] probe_delays [4] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0002_8000, 32'h0003_FFFF
  };

  fractional_delay_line_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fdl_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= !rst && !sink_hold && !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
  end

  // Hold off the receiver for a long stretch so the block backs up.
  initial begin
    wait (hold_arm);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  task automatic offer(fdl_cmd_t cmd, logic [SAMPLE_BITS-1:0] smp, logic [DELAY_BITS-1:0] dly);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {dly, smp};
    do @(posedge clk); while (!s_tready);
  endtask

  // Let every read come back, then give trailing writes time to retire.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(logic [LEN_BITS-1:0] len_raw, interp_mode_t mode);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BUFFER_LENGTH;
    cfg_data  <= len_raw;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_INTERP_MODE;
    cfg_data  <= LEN_BITS'({$urandom(), mode});
    do @(posedge clk); while (!cfg_ready);
    // now and then hit an index past the register list; it must be dropped
    if ($urandom_range(0, 2) == 0) begin
      cfg_index <= CFG_IDX_BITS'($urandom_range((1 << CFG_IDX_BITS) - 1, CFG_INTERP_MODE + 1));
      cfg_data  <= LEN_BITS'($urandom());
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_len = (len_raw < MIN_LEN) ? MIN_LEN : (len_raw > DEPTH) ? DEPTH : int'(len_raw);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return SAMPLE_BITS'($urandom_range(0, 15)) - SAMPLE_BITS'(8);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  // Favor delays near the write position and near the range bounds.
  function automatic logic [DELAY_BITS-1:0] pick_delay();
    int          span;
    int          whole;
    logic [15:0] frac;
    span  = (cur_len > 70) ? 70 : cur_len + 1;
    frac  = 16'($urandom());
    whole = $urandom_range(0, span);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: begin
        whole = $urandom_range(0, 1) ? $urandom_range(0, 3) : cur_len - $urandom_range(0, 4);
        if ($urandom_range(0, 1)) frac = '0;
      end
      2: frac = 16'h8000;
      3: whole = $urandom_range(0, cur_len);
      default: ;
    endcase
    return {whole[15:0], frac};
  endfunction

  initial begin
    logic [LEN_BITS-1:0] len_raw;
    interp_mode_t        mode;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // wait out the store clearing pass
    do @(posedge clk); while (!s_tready);

    configure(LEN_BITS'(8), MODE_LINEAR);
    foreach (extreme_samples[i]) offer(CMD_WRITE, extreme_samples[i], $urandom());
    for (int m = 0; m < 4; m++) begin
      if (m != MODE_LINEAR) begin
        drain();
        configure(LEN_BITS'(8), interp_mode_t'(m));
      end
      foreach (probe_delays[i]) offer(CMD_READ, SAMPLE_BITS'($urandom()), probe_delays[i]);
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      mode = interp_mode_t'(p % 4);
      case (p)
        0:       len_raw = LEN_BITS'(MIN_LEN);
        1:       len_raw = LEN_RESET;
        2:       len_raw = LEN_BITS'($urandom_range(0, MIN_LEN - 1));
        3:       len_raw = LEN_BITS'($urandom_range((1 << LEN_BITS) - 1, DEPTH + 1));
        4:       len_raw = LEN_BITS'(5);
        5:       len_raw = LEN_BITS'($urandom_range(6, 64));
        6:       len_raw = LEN_BITS'($urandom_range(100, 2000));
        7:       len_raw = LEN_BITS'(7);
        8: begin
          len_raw = LEN_BITS'(MIN_LEN);
          mode    = MODE_LAGRANGE;
        end
        default: begin
          len_raw = LEN_BITS'($urandom_range(MIN_LEN, 300));
          mode    = interp_mode_t'($urandom_range(0, 3));
        end
      endcase
      idle_on = (p != 5);
      configure(len_raw, mode);
      if (p == 6) hold_arm = 1'b1;
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 1))
          offer(CMD_WRITE, pick_sample(), $urandom());
        else
          offer(CMD_READ, SAMPLE_BITS'($urandom()), pick_delay());
      end
      drain();
    end

    if (errors == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
